>>> rtl/core/wsu_pkg.sv
// Package for the WS28xx-over-UART bit encoder.
// Holds the character job type and the constants shared by the front end,
// the job queue and the back end. No dependencies.
package wsu_pkg;

  // Width of one UART character and the inversion mask for the line.
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] CharMask = 7'h7F;

  // One byte yields at most four characters: three full ones plus a flush.
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CountW = 3;

  // Bit positions inside a character before inversion.
  localparam int unsigned Slot0DataBit = 0;
  localparam int unsigned Slot1SyncBit = 2;
  localparam int unsigned Slot1DataBit = 3;
  localparam int unsigned Slot2SyncBit = 5;
  localparam int unsigned Slot2DataBit = 6;

  // Job queue between front and back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned QueueCntW = 2;

  typedef logic [CharW-1:0] char_t;
  typedef logic [1:0] slot_t;

  // All characters caused by one input byte, ready to send in order.
  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic [CountW-1:0]    count;
  } job_t;

endpackage

>>> rtl/core/wsu_if.sv
// Channel interfaces of the WS28xx-over-UART bit encoder.
// Depends on nothing; payload widths follow the field widths.
interface wsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_byte;
  logic       frame_end;

  modport source (output valid, output led_byte, output frame_end, input ready);
  modport sink (input valid, input led_byte, input frame_end, output ready);
endinterface

interface wsu_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] uart_char;
  logic       last_of_run;

  modport source (output valid, output uart_char, output last_of_run, input ready);
  modport sink (input valid, input uart_char, input last_of_run, output ready);
endinterface

>>> rtl/core/wsu_front.sv
// Front end: accepts LED bytes, splits their bits into slots and builds the
// characters of one byte as a job. Depends on wsu_pkg and wsu_if.
module wsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsu_in_if.sink        in_i,
  input  logic          queue_ready_i,
  output logic          push_o,
  output wsu_pkg::job_t job_o
);
  import wsu_pkg::*;

  typedef struct packed {
    job_t  job;
    char_t partial;
    slot_t slot;
  } enc_t;

  // Place eight data bits into slots, emitting each full character inverted.
  function automatic enc_t encode(char_t pc, slot_t sl, logic [7:0] b, logic fe);
    enc_t              r;
    char_t             c;
    slot_t             s;
    logic [CountW-1:0] n;
    logic              bit_v;
    r = '0;
    c = pc;
    s = (sl == 2'd3) ? 2'd0 : sl;
    n = '0;
    for (int i = 7; i >= 0; i--) begin
      bit_v = b[3'(i)];
      case (s)
        2'd1: begin
          c[Slot1SyncBit] = 1'b1;
          c[Slot1DataBit] = c[Slot1DataBit] | bit_v;
        end
        2'd2: begin
          c[Slot2SyncBit] = 1'b1;
          c[Slot2DataBit] = c[Slot2DataBit] | bit_v;
        end
        default: begin
          c[Slot0DataBit] = c[Slot0DataBit] | bit_v;
        end
      endcase
      if (s == 2'd2) begin
        r.job.chars[n[1:0]] = c ^ CharMask;
        n = n + 1'b1;
        c = '0;
        s = 2'd0;
      end else begin
        s = s + 1'b1;
      end
    end
    // Flush a partly filled character at the end of a frame.
    if (fe && (s != 2'd0)) begin
      r.job.chars[n[1:0]] = c ^ CharMask;
      n = n + 1'b1;
      c = '0;
      s = 2'd0;
    end
    r.job.count = n;
    r.partial   = c;
    r.slot      = s;
    return r;
  endfunction

  char_t partial_q, partial_d;
  slot_t slot_q, slot_d;
  enc_t  enc;
  logic  accept;

  // Encoding of the offered byte against the current character state.
  assign enc        = encode(partial_q, slot_q, in_i.led_byte, in_i.frame_end);
  assign in_i.ready = queue_ready_i;
  assign accept     = in_i.valid & queue_ready_i;
  assign push_o     = accept;
  assign job_o      = enc.job;
  assign partial_d  = accept ? enc.partial : partial_q;
  assign slot_d     = accept ? enc.slot : slot_q;

  // Character state carried from byte to byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      slot_q    <= '0;
    end else begin
      partial_q <= partial_d;
      slot_q    <= slot_d;
    end
  end

endmodule

>>> rtl/core/wsu_queue.sv
// Two-entry job queue between the front and back end.
// Depends on wsu_pkg.
module wsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsu_pkg::job_t push_job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output wsu_pkg::job_t head_o
);
  import wsu_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign ready_o      = (cnt_q != QueueCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i & ready_o;
  assign do_pop       = pop_i & head_valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Job storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

>>> rtl/core/wsu_back.sv
// Back end: sends the head job's characters one request per cycle unless out_o stalls.
// Depends on wsu_pkg and wsu_if.
module wsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  wsu_pkg::job_t head_i,
  output logic          pop_o,
  wsu_out_if.source     out_o,
  output logic [1:0]    idx_o
);
  import wsu_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       is_last, fire;

  assign is_last           = ({1'b0, idx_q} + 1'b1) == head_i.count;
  assign fire              = head_valid_i & out_o.ready;
  assign out_o.valid       = head_valid_i;
  assign out_o.uart_char   = head_i.chars[idx_q];
  assign out_o.last_of_run = is_last;
  assign pop_o             = fire & is_last;
  assign idx_o             = idx_q;

  // Character index inside the head job; back to zero when the job leaves.
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> rtl/core/ws28xx_uart_bit_encoder_top.sv
// Top level of the WS28xx-over-UART bit encoder.
// Depends on wsu_pkg, wsu_if, wsu_front, wsu_queue and wsu_back.
//
// Usage:
//   in_i carries LED data bytes (led_byte, sent MSB first) with frame_end set
//   on the last byte of a frame. out_o carries seven-bit UART characters,
//   already inverted for the line, with last_of_run set on the final
//   character caused by each byte. Both channels move a request when valid
//   and ready are high at a rising clock edge.
//   Every data bit fills a three-bit slot; three slots make a character, so
//   a byte gives two or three full characters, and a frame end flushes a
//   partly filled character as one more, so at most four.
//   The first character of a byte is offered in the cycle after the byte
//   is taken when no earlier characters are waiting; otherwise it follows
//   them. The back end sends one character per cycle while out_o.ready is
//   high, and a byte gives it two to four characters to send; that output
//   port sets the throughput. A two-job queue lets the front take the next
//   byte while characters still wait to go out.
//   When the receiver stalls, the characters are held and the queue fills;
//   in_i.ready drops once both jobs are waiting.
//   Reset empties the queue and starts a fresh character at slot zero.
module ws28xx_uart_bit_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsu_in_if.sink     in_i,
  wsu_out_if.source  out_o
);
  import wsu_pkg::*;

  logic       push, queue_ready, pop, head_valid;
  job_t       push_job, head_job;
  logic [1:0] idx;

  wsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .job_o         (push_job)
  );

  wsu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .ready_o      (queue_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  wsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_o        (out_o),
    .idx_o        (idx)
  );

  // Every job holds two to four characters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (head_job.count >= 3'd2 && head_job.count <= 3'd4))
    else $error("job character count out of range");

  // The character index stays inside the head job.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> ({1'b0, idx} < head_job.count))
    else $error("character index beyond head job");

  // After a byte is accepted, output is offered in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_o.valid)
    else $error("accepted byte produced no pending output");

endmodule
